// File: hdl/mm_pkg.sv
// shared constants, types and arithmetic helpers for the matrix multiplier
package mm_pkg;

    localparam int DEFAULT_MAX_DIM = 8;

    localparam int VALUE_W     = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 4;
    localparam int ACC_W       = 64;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 2'd2;

    localparam logic REG_INNER_DIM = 1'b0;
    localparam logic REG_B_COLS    = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic init;
        logic issue;
        logic err_load;
        logic clear;
    } mm_cmd_t;

    typedef struct packed {
        logic dim_err;
        logic cap_err;
        logic empty;
        logic k_last;
        logic j_last;
        logic row_last;
        logic slot_free;
        logic pipe_busy;
    } mm_sts_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] sum;
        logic signed [ACC_W-1:0] res;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            res = sum[ACC_W-1:0];
        end
        return res;
    endfunction

    // q32.32 to q16.16: floor, then saturate
    function automatic logic signed [VALUE_W-1:0] to_q16(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [VALUE_W-1:0] res;
        if (acc >= 64'sh0000_8000_0000_0000)
        begin
            res = 32'sh7FFF_FFFF;
        end
        else if (acc < 64'shFFFF_8000_0000_0000)
        begin
            res = 32'sh8000_0000;
        end
        else
        begin
            res = acc[47:16];
        end
        return res;
    endfunction

endpackage

// File: hdl/mm_in_if.sv
// request channel carrying load and compute items
interface mm_in_if;
    logic                              valid;
    logic                              ready;
    logic [mm_pkg::FUNC_W-1:0]         func;
    logic signed [mm_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

// File: hdl/mm_out_if.sv
// result channel carrying product elements and error codes
interface mm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mm_pkg::VALUE_W-1:0] result_value;
    logic [mm_pkg::STATUS_W-1:0]       status;
    logic                              last;

    modport source (output valid, output result_value, output status, output last, input ready);
    modport sink (input valid, input result_value, input status, input last, output ready);
endinterface

// File: hdl/matrix_multiply.sv
// top level of the fixed-point matrix multiplier
// Load items (A or B element) are taken one per cycle. A compute item holds off
// further requests while the single multiply-accumulate unit walks the product:
// each product element waits in a start state until the pipeline is empty and
// the result slot is free, then makes inner_dim store reads, and the multiply,
// accumulate and rounding stages drain into the output register. The stores are
// plain memories with no clearing pass; every compute resets the load counts.
module matrix_multiply #(
    parameter int MAX_DIM = mm_pkg::DEFAULT_MAX_DIM
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mm_in_if.sink                           in_ch,
    mm_out_if.source                        out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                            pready
);

    logic [mm_pkg::CFG_W-1:0] inner_dim;
    logic [mm_pkg::CFG_W-1:0] b_cols;
    mm_pkg::mm_cmd_t          cmd;
    mm_pkg::mm_sts_t          sts;

    mm_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .inner_dim (inner_dim),
        .b_cols    (b_cols)
    );

    mm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_ch.func),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .inner_dim        (inner_dim),
        .b_cols           (b_cols),
        .in_value         (in_ch.value),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_result_value (out_ch.result_value),
        .out_status       (out_ch.status),
        .out_last         (out_ch.last)
    );

endmodule

// File: hdl/mm_regs.sv
// apb configuration registers: inner dimension and b column count
module mm_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                            pready,
    output logic [mm_pkg::CFG_W-1:0]        inner_dim,
    output logic [mm_pkg::CFG_W-1:0]        b_cols
);

    localparam int DW = mm_pkg::APB_DATA_W;
    localparam int FW = mm_pkg::CFG_W;

    logic [FW-1:0] inner_dim_reg;
    logic [FW-1:0] b_cols_reg;
    logic          wr_en;
    logic          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[mm_pkg::REG_SEL_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_dim_reg <= mm_pkg::CFG_RESET;
            b_cols_reg    <= mm_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                mm_pkg::REG_INNER_DIM: inner_dim_reg <= pwdata[FW-1:0];
                mm_pkg::REG_B_COLS:    b_cols_reg    <= pwdata[FW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            mm_pkg::REG_INNER_DIM: prdata = DW'(inner_dim_reg);
            mm_pkg::REG_B_COLS:    prdata = DW'(b_cols_reg);
        endcase
    end

    assign inner_dim = inner_dim_reg;
    assign b_cols    = b_cols_reg;

endmodule

// File: hdl/mm_ctrl.sv
// controller state machine sequencing loads, shape checks and the mac walk
module mm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [mm_pkg::FUNC_W-1:0]   in_func,
    output logic                        in_ready,
    input  mm_pkg::mm_sts_t             sts,
    output mm_pkg::mm_cmd_t             cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_ERR    = 3'd2;
    localparam logic [2:0] ST_ELEM   = 3'd3;
    localparam logic [2:0] ST_ISSUE  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority case (in_func)
                        mm_pkg::FUNC_LOAD_A:  cmd.load_a = 1'b1;
                        mm_pkg::FUNC_LOAD_B:  cmd.load_b = 1'b1;
                        mm_pkg::FUNC_COMPUTE: state_next = ST_CHECK;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (sts.dim_err || sts.cap_err)
                begin
                    state_next = ST_ERR;
                end
                else if (sts.empty)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_ELEM;
                end
            end
            ST_ERR:
            begin
                if (sts.slot_free)
                begin
                    cmd.err_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ELEM:
            begin
                if (sts.slot_free)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (sts.k_last)
                begin
                    state_next = (sts.j_last && sts.row_last) ? ST_FINISH : ST_ELEM;
                end
            end
            ST_FINISH:
            begin
                if (!sts.pipe_busy)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.pipe_busy)
        else $error("request taken while the mac pipeline is busy");

    a_issue_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ELEM) && sts.slot_free |=> cmd.issue)
        else $error("element started without issuing a mac step");
`endif

endmodule

// File: hdl/mm_datapath.sv
// matrix stores, load counters, walk counters and the read/multiply/accumulate path
module mm_datapath #(
    parameter int MAX_DIM = mm_pkg::DEFAULT_MAX_DIM
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mm_pkg::mm_cmd_t                   cmd,
    output mm_pkg::mm_sts_t                   sts,
    input  logic [mm_pkg::CFG_W-1:0]          inner_dim,
    input  logic [mm_pkg::CFG_W-1:0]          b_cols,
    input  logic signed [mm_pkg::VALUE_W-1:0] in_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mm_pkg::VALUE_W-1:0] out_result_value,
    output logic [mm_pkg::STATUS_W-1:0]       out_status,
    output logic                              out_last
);

    localparam int CAP = MAX_DIM * MAX_DIM;
    localparam int AW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 2);
    localparam int FW  = mm_pkg::CFG_W;
    localparam int EW  = ((CW > FW) ? CW : FW) + FW;
    localparam int VW  = mm_pkg::VALUE_W;
    localparam int XW  = mm_pkg::ACC_W;
    localparam int SW  = mm_pkg::STATUS_W;

    logic signed [VW-1:0] a_mem [CAP];
    logic signed [VW-1:0] b_mem [CAP];

    logic [CW-1:0] a_cnt_reg;
    logic [CW-1:0] b_cnt_reg;
    logic [CW-1:0] abase_reg;
    logic [CW-1:0] bptr_reg;
    logic [FW-1:0] k_reg;
    logic [FW-1:0] j_reg;

    logic signed [VW-1:0] rd_a_reg;
    logic signed [VW-1:0] rd_b_reg;
    logic                 s1_valid_reg;
    logic                 s1_first_reg;
    logic                 s1_elast_reg;
    logic                 s1_plast_reg;
    logic signed [XW-1:0] prod_reg;
    logic                 s2_valid_reg;
    logic                 s2_first_reg;
    logic                 s2_elast_reg;
    logic                 s2_plast_reg;
    logic signed [XW-1:0] acc_reg;
    logic                 conv_valid_reg;
    logic                 conv_last_reg;

    logic                 out_valid_reg;
    logic signed [VW-1:0] result_reg;
    logic [SW-1:0]        status_reg;
    logic                 last_reg;

    logic [EW-1:0]        id_e;
    logic [EW-1:0]        bc_e;
    logic [EW-1:0]        a_cnt_e;
    logic [EW-1:0]        b_cnt_e;
    logic [EW-1:0]        abase_e;
    logic [FW-1:0]        id_m1;
    logic [FW-1:0]        bc_m1;
    logic [CW-1:0]        addr_a;
    logic                 a_room;
    logic                 b_room;
    logic                 plast;
    logic signed [XW-1:0] prod_next;
    logic signed [XW-1:0] acc_base;
    logic signed [XW-1:0] acc_next;

    assign id_e    = EW'(inner_dim);
    assign bc_e    = EW'(b_cols);
    assign a_cnt_e = EW'(a_cnt_reg);
    assign b_cnt_e = EW'(b_cnt_reg);
    assign abase_e = EW'(abase_reg);
    assign id_m1   = inner_dim - FW'(1);
    assign bc_m1   = b_cols - FW'(1);
    assign addr_a  = abase_reg + CW'(k_reg);
    assign a_room  = a_cnt_reg < CW'(CAP);
    assign b_room  = b_cnt_reg < CW'(CAP);

    // b rows equal inner_dim exactly when the b count falls in this window
    assign sts.dim_err  = (inner_dim == '0) || (b_cols == '0)
                          || (b_cnt_e < id_e * bc_e)
                          || (b_cnt_e >= (id_e + EW'(1)) * bc_e);
    assign sts.cap_err  = (a_cnt_reg > CW'(CAP)) || (b_cnt_reg > CW'(CAP))
                          || (id_e > EW'(MAX_DIM)) || (bc_e > EW'(MAX_DIM))
                          || (a_cnt_e >= EW'(MAX_DIM + 1) * id_e);
    assign sts.empty    = a_cnt_e < id_e;
    assign sts.k_last   = (k_reg == id_m1);
    assign sts.j_last   = (j_reg == bc_m1);
    assign sts.row_last = (abase_e + id_e + id_e) > a_cnt_e;
    assign sts.pipe_busy = s1_valid_reg || s2_valid_reg || conv_valid_reg;
    assign sts.slot_free = !sts.pipe_busy && (!out_valid_reg || out_ready);

    assign plast = sts.k_last && sts.j_last && sts.row_last;

    // load counters saturate one past capacity to mark overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load_a)
            begin
                a_cnt_reg <= a_room ? a_cnt_reg + CW'(1) : CW'(CAP + 1);
            end
            if (cmd.load_b)
            begin
                b_cnt_reg <= b_room ? b_cnt_reg + CW'(1) : CW'(CAP + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_a && a_room)
        begin
            a_mem[a_cnt_reg[AW-1:0]] <= in_value;
        end
        if (cmd.issue)
        begin
            rd_a_reg <= a_mem[addr_a[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b && b_room)
        begin
            b_mem[b_cnt_reg[AW-1:0]] <= in_value;
        end
        if (cmd.issue)
        begin
            rd_b_reg <= b_mem[bptr_reg[AW-1:0]];
        end
    end

    // walk counters: k inner, j product column, abase row start in a
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            j_reg     <= '0;
            abase_reg <= '0;
            bptr_reg  <= '0;
        end
        else if (cmd.init)
        begin
            k_reg     <= '0;
            j_reg     <= '0;
            abase_reg <= '0;
            bptr_reg  <= '0;
        end
        else if (cmd.issue)
        begin
            if (sts.k_last)
            begin
                k_reg <= '0;
                if (sts.j_last)
                begin
                    j_reg     <= '0;
                    bptr_reg  <= '0;
                    abase_reg <= abase_reg + CW'(inner_dim);
                end
                else
                begin
                    j_reg    <= j_reg + FW'(1);
                    bptr_reg <= CW'(j_reg) + CW'(1);
                end
            end
            else
            begin
                k_reg    <= k_reg + FW'(1);
                bptr_reg <= bptr_reg + CW'(b_cols);
            end
        end
    end

    assign prod_next = rd_a_reg * rd_b_reg;
    assign acc_base  = s2_first_reg ? '0 : acc_reg;
    assign acc_next  = mm_pkg::sat_add(acc_base, prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_first_reg   <= 1'b0;
            s1_elast_reg   <= 1'b0;
            s1_plast_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_first_reg   <= 1'b0;
            s2_elast_reg   <= 1'b0;
            s2_plast_reg   <= 1'b0;
            conv_valid_reg <= 1'b0;
            conv_last_reg  <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            s1_valid_reg   <= cmd.issue;
            s1_first_reg   <= (k_reg == '0);
            s1_elast_reg   <= sts.k_last;
            s1_plast_reg   <= plast;
            s2_valid_reg   <= s1_valid_reg;
            s2_first_reg   <= s1_first_reg;
            s2_elast_reg   <= s1_elast_reg;
            s2_plast_reg   <= s1_plast_reg;
            conv_valid_reg <= s2_valid_reg && s2_elast_reg;
            conv_last_reg  <= s2_plast_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    // output register, loaded only when the slot was free at element start or at the error load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (conv_valid_reg || cmd.err_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.err_load)
        begin
            result_reg <= '0;
            status_reg <= sts.dim_err ? mm_pkg::STATUS_MISMATCH : mm_pkg::STATUS_CAPACITY;
            last_reg   <= 1'b1;
        end
        else if (conv_valid_reg)
        begin
            result_reg <= mm_pkg::to_q16(acc_reg);
            status_reg <= mm_pkg::STATUS_OK;
            last_reg   <= conv_last_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_result_value = result_reg;
    assign out_status       = status_reg;
    assign out_last         = last_reg;

`ifndef NO_ASSERTIONS
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        conv_valid_reg |-> !(out_valid_reg && !out_ready))
        else $error("finished element would overwrite an untaken result");

    a_single_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.err_load && conv_valid_reg))
        else $error("error and product result loaded together");

    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (addr_a < CW'(CAP)) && (bptr_reg < CW'(CAP)))
        else $error("mac read address beyond store capacity");
`endif

endmodule
